// ----- rtl/query_cookie_param_decoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Query/cookie decoder assertion macros
// Assertion macros shared by the query/cookie decoder RTL.
// ----------------------------------------------------------------------------
`ifndef QUERY_COOKIE_PARAM_DECODER_TOP_ASSERT_SVH
`define QUERY_COOKIE_PARAM_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QCPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qcpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qcpd assertion failed");

`endif

// ----- rtl/qcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// qcpd_pkg
// Types, character codes and helpers for the query/cookie parameter decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qcpd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Configuration register indexes.
    localparam logic CFG_COOKIE_MODE = 1'b0;
    localparam logic CFG_MAX_TOKENS  = 1'b1;

    typedef enum logic [1:0] {
        ESC_IDLE   = 2'd0,
        ESC_FIRST  = 2'd1,
        ESC_SECOND = 2'd2
    } t_esc_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic       token_is_key;
        logic       token_kept;
        logic [7:0] token_count;
        logic       overflow;
        logic       string_done;
        logic       run_last;
    } t_result;

    // Bit 4 flags a hex digit, bits 3..0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/query_cookie_param_decoder_top.sv -----
// A result enters the queue register and appears on the master side in the cycle
// after its byte is accepted, when no older results wait in the queue.
// Throughput: one byte per cycle while the result side keeps up; the last byte of a
// string gives two results when the byte itself yields one (a decoded byte or a token
// end) and the three-entry result queue absorbs the extra result.
// Reset: synchronous, active low; parser state, queue count and registers return to
// their reset values (query mode, token limit 255).
// ----------------------------------------------------------------------------
// query_cookie_param_decoder_top
// Streaming urlencoded query / cookie string tokenizer and percent-decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "query_cookie_param_decoder_top_assert.svh"

module query_cookie_param_decoder_top
    import qcpd_pkg::*;
#(
    parameter int MAX_TOKENS = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata,
    // Input stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic        i_s_axis_tlast,   // string_end
    // Result stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] out_byte, [8] byte_valid, [9] token_end, [10] token_is_key,
    // [11] token_kept, [19:12] token_count, [20] overflow, [21] string_done,
    // [23:22] zero
    output logic [23:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast    // run_last
);

    // The limit in force is the smaller of the register and the parameter. The
    // register is 8 bits wide, so the cap never needs more than 8 bits.
    localparam int         LIM_CAP = (MAX_TOKENS < 255) ? MAX_TOKENS : 255;
    localparam logic [7:0] CAP8    = 8'(LIM_CAP);
    localparam int         QDEPTH  = 3;

    // Configuration registers.
    logic       r_cookie_mode;
    logic [7:0] r_max_tokens;

    // Parser state.
    t_esc_phase r_esc_phase,     n_esc_phase;
    logic [4:0] r_esc_digit,     n_esc_digit;
    logic       r_seg_started,   n_seg_started;
    logic       r_seg_trunc,     n_seg_trunc;
    logic       r_value_pending, n_value_pending;
    logic [7:0] r_tokens,        n_tokens;
    logic       r_stopped,       n_stopped;

    // Result queue: entry 0 is the head.
    t_result    r_q [QDEPTH];
    t_result    n_q [QDEPTH];
    logic [1:0] r_cnt, n_cnt;

    logic       w_accept;
    logic       w_pop;
    logic [1:0] w_base;
    logic [7:0] w_limit;
    logic [7:0] w_b;
    logic       w_last;
    logic       w_is_eq;
    logic       w_is_sep;
    logic       w_hold_space;
    logic [4:0] w_hex;
    logic       w_a_valid;
    logic       w_b_valid;
    t_result    w_res_a;
    t_result    w_res_b;
    t_result    w_first;
    logic [1:0] w_nres;
    logic [1:0] w_slot1;

    assign w_limit = (r_max_tokens < CAP8) ? r_max_tokens : CAP8;
    assign w_b     = i_s_axis_tdata;
    assign w_last  = i_s_axis_tlast;
    assign w_hex   = hex_digit(w_b);

    // Ready whenever two free entries remain after this cycle's pop, so a byte
    // can be taken while older results still wait downstream.
    assign w_pop           = (r_cnt != 2'd0) && i_m_axis_tready;
    assign w_base          = r_cnt - {1'b0, w_pop};
    assign o_s_axis_tready = (w_base <= 2'd1);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Decode one byte. Result A comes from the byte itself, result B from the
    // end of the string. State moves through both steps in that order.
    always_comb begin
        n_esc_phase     = r_esc_phase;
        n_esc_digit     = r_esc_digit;
        n_seg_started   = r_seg_started;
        n_seg_trunc     = r_seg_trunc;
        n_value_pending = r_value_pending;
        n_tokens        = r_tokens;
        n_stopped       = r_stopped;
        w_a_valid       = 1'b0;
        w_b_valid       = 1'b0;
        w_res_a         = '0;
        w_res_b         = '0;

        w_is_eq      = (w_b == CH_EQUALS);
        w_is_sep     = r_cookie_mode ? (w_b == CH_SEMI) : (w_b == CH_AMP);
        w_hold_space = r_cookie_mode && (w_b == CH_SPACE);

        if (!r_stopped) begin
            if (w_hold_space) begin
                // A space after the first byte cuts the cookie token, and any
                // open escape is dropped with the rest.
                if (r_seg_started && !r_seg_trunc) begin
                    n_seg_trunc = 1'b1;
                    n_esc_phase = ESC_IDLE;
                    n_esc_digit = 5'd0;
                end
            end else if (w_is_eq || w_is_sep) begin
                n_value_pending      = w_is_eq;
                w_a_valid            = 1'b1;
                w_res_a.token_end    = 1'b1;
                w_res_a.token_is_key = w_is_eq;
                if (r_tokens >= w_limit) begin
                    n_stopped = 1'b1;
                end else begin
                    n_tokens           = r_tokens + 8'd1;
                    w_res_a.token_kept = 1'b1;
                end
                n_esc_phase   = ESC_IDLE;
                n_esc_digit   = 5'd0;
                n_seg_started = 1'b0;
                n_seg_trunc   = 1'b0;
            end else begin
                n_seg_started = 1'b1;
                if (!r_seg_trunc) begin
                    unique case (r_esc_phase)
                        ESC_IDLE: begin
                            if (w_b == CH_PERCENT) begin
                                n_esc_phase = ESC_FIRST;
                            end else if (!r_cookie_mode && (w_b == CH_PLUS)) begin
                                w_a_valid          = 1'b1;
                                w_res_a.byte_valid = 1'b1;
                                w_res_a.out_byte   = CH_SPACE;
                            end else begin
                                w_a_valid          = 1'b1;
                                w_res_a.byte_valid = 1'b1;
                                w_res_a.out_byte   = w_b;
                            end
                        end
                        ESC_FIRST: begin
                            n_esc_digit = w_hex;
                            n_esc_phase = ESC_SECOND;
                        end
                        default: begin
                            // A non-hex first digit gives zero; a non-hex second
                            // digit leaves the first digit's value alone.
                            w_a_valid          = 1'b1;
                            w_res_a.byte_valid = 1'b1;
                            if (r_esc_digit[4]) begin
                                w_res_a.out_byte = w_hex[4] ?
                                    {r_esc_digit[3:0], w_hex[3:0]} :
                                    {4'd0, r_esc_digit[3:0]};
                            end
                            n_esc_phase = ESC_IDLE;
                            n_esc_digit = 5'd0;
                        end
                    endcase
                end
            end
        end

        w_res_a.token_count = n_tokens;
        w_res_a.overflow    = n_stopped;
        w_res_a.run_last    = !w_last;

        if (w_last) begin
            w_b_valid           = 1'b1;
            w_res_b.string_done = 1'b1;
            w_res_b.run_last    = 1'b1;
            if (!n_stopped) begin
                // The final segment is stored only when it follows an '='.
                w_res_b.token_end = 1'b1;
                if (n_value_pending) begin
                    if (n_tokens >= w_limit) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_tokens           = n_tokens + 8'd1;
                        w_res_b.token_kept = 1'b1;
                    end
                end
            end
            w_res_b.token_count = n_tokens;
            w_res_b.overflow    = n_stopped;
            // Back to a clean parser for the next string.
            n_esc_phase     = ESC_IDLE;
            n_esc_digit     = 5'd0;
            n_seg_started   = 1'b0;
            n_seg_trunc     = 1'b0;
            n_value_pending = 1'b0;
            n_tokens        = 8'd0;
            n_stopped       = 1'b0;
        end
    end

    // Queue update: shift on pop, then append this byte's results behind the
    // entries that remain.
    assign w_first = w_a_valid ? w_res_a : w_res_b;
    assign w_nres  = {1'b0, w_a_valid} + {1'b0, w_b_valid};
    assign w_slot1 = w_base + 2'd1;

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (w_pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            if (w_accept && (w_nres != 2'd0) && (2'(i) == w_base)) begin
                n_q[i] = w_first;
            end
            if (w_accept && (w_nres == 2'd2) && (2'(i) == w_slot1)) begin
                n_q[i] = w_res_b;
            end
        end
        n_cnt = w_accept ? (w_base + w_nres) : w_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cookie_mode   <= 1'b0;
            r_max_tokens    <= 8'd255;
            r_esc_phase     <= ESC_IDLE;
            r_esc_digit     <= 5'd0;
            r_seg_started   <= 1'b0;
            r_seg_trunc     <= 1'b0;
            r_value_pending <= 1'b0;
            r_tokens        <= 8'd0;
            r_stopped       <= 1'b0;
            r_cnt           <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COOKIE_MODE: r_cookie_mode <= i_cfg_wdata[0];
                    CFG_MAX_TOKENS:  r_max_tokens  <= i_cfg_wdata;
                endcase
            end
            if (w_accept) begin
                r_esc_phase     <= n_esc_phase;
                r_esc_digit     <= n_esc_digit;
                r_seg_started   <= n_seg_started;
                r_seg_trunc     <= n_seg_trunc;
                r_value_pending <= n_value_pending;
                r_tokens        <= n_tokens;
                r_stopped       <= n_stopped;
            end
            r_cnt <= n_cnt;
        end
    end

    // Queue payload carries no reset.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {2'b00, r_q[0].string_done, r_q[0].overflow,
                              r_q[0].token_count, r_q[0].token_kept,
                              r_q[0].token_is_key, r_q[0].token_end,
                              r_q[0].byte_valid, r_q[0].out_byte};
    assign o_m_axis_tlast  = r_q[0].run_last;

    // The stored token count never passes the limit in force.
    `QCPD_ASSERT_SAME(a_tokens_in_limit, i_clk, i_rst_n, 1'b1, r_tokens <= w_limit)
    // The last byte of a string leaves a clean count and no overflow.
    `QCPD_ASSERT_NEXT(a_string_clears, i_clk, i_rst_n, w_accept && w_last,
                      (r_tokens == 8'd0) && !r_stopped && !r_value_pending)
    // A push never overruns the queue.
    `QCPD_ASSERT_SAME(a_queue_room, i_clk, i_rst_n, w_accept,
                      ({1'b0, w_base} + {1'b0, w_nres}) <= 3'(QDEPTH))

endmodule

`default_nettype wire

// ----- bench/query_cookie_param_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// Query/cookie decoder result checker
// Watches the configuration port and both streams of the decoder. For each
// accepted input word it predicts the decoded result words, and it compares
// every accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module query_cookie_param_decoder_checker
    import qcpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 40;

    // Shadow registers and parser state.
    logic       cookie_on;
    logic [7:0] token_limit;
    t_esc_phase esc_phase;
    logic [4:0] esc_digit;
    logic       seg_started;
    logic       seg_cut;
    logic       value_open;
    logic [7:0] stored;
    logic       halted;

    t_result decoded_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Bit 4 set for a hex digit, bits 3..0 its value; zero otherwise.
    function automatic logic [4:0] hex_of(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, 4'(b - "0")};
        end else if (b >= "a" && b <= "f") begin
            r = {1'b1, 4'(b - "a" + 8'd10)};
        end else if (b >= "A" && b <= "F") begin
            r = {1'b1, 4'(b - "A" + 8'd10)};
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      o_checked, name, got, want));
        end
    endtask

    task automatic push_word(input logic [7:0] val, input logic bv, input logic te,
                             input logic key, input logic kept);
        t_result r;
        r.out_byte     = val;
        r.byte_valid   = bv;
        r.token_end    = te;
        r.token_is_key = key;
        r.token_kept   = kept;
        r.token_count  = stored;
        r.overflow     = halted;
        r.string_done  = 1'b0;
        r.run_last     = 1'b0;
        decoded_q.push_back(r);
    endtask

    task automatic clear_segment();
        esc_phase   = ESC_IDLE;
        esc_digit   = 5'd0;
        seg_started = 1'b0;
        seg_cut     = 1'b0;
    endtask

    task automatic clear_string();
        clear_segment();
        value_open = 1'b0;
        stored     = 8'd0;
        halted     = 1'b0;
    endtask

    // A token ends; it is stored if allowed and the limit has room.
    task automatic close_token(input logic is_key, input logic storable);
        logic kept;
        kept = 1'b0;
        if (storable) begin
            if (stored >= token_limit) begin
                halted = 1'b1;
            end else begin
                stored++;
                kept = 1'b1;
            end
        end
        clear_segment();
        push_word(8'd0, 1'b0, 1'b1, is_key, kept);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic at_end);
        int         n_before;
        logic       is_sep;
        logic [4:0] h;
        logic [7:0] v;
        t_result    r;
        n_before = decoded_q.size();
        if (!halted) begin
            is_sep = cookie_on ? (b == CH_SEMI) : (b == CH_AMP);
            if (cookie_on && b == CH_SPACE) begin
                // A space after token content cuts the rest of the token.
                if (seg_started && !seg_cut) begin
                    seg_cut   = 1'b1;
                    esc_phase = ESC_IDLE;
                    esc_digit = 5'd0;
                end
            end else if (b == CH_EQUALS || is_sep) begin
                value_open = (b == CH_EQUALS);
                close_token(b == CH_EQUALS, 1'b1);
            end else begin
                seg_started = 1'b1;
                if (!seg_cut) begin
                    case (esc_phase)
                        ESC_IDLE: begin
                            if (b == CH_PERCENT) begin
                                esc_phase = ESC_FIRST;
                            end else if (!cookie_on && b == CH_PLUS) begin
                                push_word(CH_SPACE, 1'b1, 1'b0, 1'b0, 1'b0);
                            end else begin
                                push_word(b, 1'b1, 1'b0, 1'b0, 1'b0);
                            end
                        end
                        ESC_FIRST: begin
                            esc_digit = hex_of(b);
                            esc_phase = ESC_SECOND;
                        end
                        default: begin
                            v = 8'd0;
                            if (esc_digit[4]) begin
                                h = hex_of(b);
                                v = {4'd0, esc_digit[3:0]};
                                if (h[4]) begin
                                    v = {esc_digit[3:0], h[3:0]};
                                end
                            end
                            esc_phase = ESC_IDLE;
                            esc_digit = 5'd0;
                            push_word(v, 1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    endcase
                end
            end
        end
        if (at_end) begin
            // The final segment only counts after an equals sign.
            if (!halted) begin
                close_token(1'b0, value_open);
            end else begin
                push_word(8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            end
            r = decoded_q.pop_back();
            r.string_done = 1'b1;
            decoded_q.push_back(r);
            clear_string();
        end
        if (decoded_q.size() > n_before) begin
            r = decoded_q.pop_back();
            r.run_last = 1'b1;
            decoded_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cookie_on   = 1'b0;
            token_limit = 8'd255;
            clear_string();
            decoded_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_COOKIE_MODE) begin
                    cookie_on = i_cfg_wdata[0];
                end else begin
                    token_limit = i_cfg_wdata;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h last %b",
                                              i_m_tdata, i_m_tlast));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", i_m_tdata[7:0], want.out_byte);
                    check_field("byte_valid", 8'(i_m_tdata[8]), 8'(want.byte_valid));
                    check_field("token_end", 8'(i_m_tdata[9]), 8'(want.token_end));
                    check_field("token_is_key", 8'(i_m_tdata[10]), 8'(want.token_is_key));
                    check_field("token_kept", 8'(i_m_tdata[11]), 8'(want.token_kept));
                    check_field("token_count", i_m_tdata[19:12], want.token_count);
                    check_field("overflow", 8'(i_m_tdata[20]), 8'(want.overflow));
                    check_field("string_done", 8'(i_m_tdata[21]), 8'(want.string_done));
                    check_field("padding", 8'(i_m_tdata[23:22]), 8'd0);
                    check_field("run_last", 8'(i_m_tlast), 8'(want.run_last));
                end
                o_checked++;
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

// ----- bench/tb_query_cookie_param_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Query/cookie decoder testbench
// Drives directed and random query and cookie strings through the decoder
// under several register settings, with random idle cycles on the input and
// random back-pressure on the output. A checker beside the block predicts
// and compares every result word; this module only drives and judges.
// ----------------------------------------------------------------------------
module tb_query_cookie_param_decoder_top;
    import qcpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound on the whole run, far above the slowest legal run.
    localparam int CYCLE_LIMIT  = 600000;
    // Random bytes sent under each register setting.
    localparam int PHASE_BYTES  = 115;
    localparam int PHASE_COUNT  = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending_words;
    int checked_words;

    int cycle_count;
    int bytes_sent;
    int strings_sent;
    int settings_used;

    // Input idling runs in calm stretches (no gaps) or busy ones.
    bit src_calm;
    bit sink_calm;
    int sink_hold;

    // Bytes of the string being assembled for transmission.
    logic [7:0] line_q[$];

    query_cookie_param_decoder_top #(
        .MAX_TOKENS (255)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    query_cookie_param_decoder_checker u_decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_words),
        .o_checked    (checked_words)
    );

    // Every input of the block holds a known value from time zero.
    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_COOKIE_MODE;
        cfg_wdata = 8'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        m_tready  = 1'b1;
        cycle_count   = 0;
        bytes_sent    = 0;
        strings_sent  = 0;
        settings_used = 0;
        src_calm  = 1'b0;
        sink_calm = 1'b0;
        sink_hold = 0;
    end

    always #1 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d result words outstanding.",
                     cycle_count, pending_words);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Short or long random gap; none at all during a calm stretch.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // The result sink stalls at random. Ready changes only on falling edges,
    // so the block sees a stable value at every rising edge.
    always @(negedge clk) begin
        if ($urandom_range(0, 149) == 0) begin
            sink_calm = ~sink_calm;
        end
        if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) begin
                sink_hold = pick_gap(sink_calm);
            end
        end
    end

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10) begin
            return 8'("0" + v);
        end
        return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_q.push_back(s[i]);
        end
    endtask

    // One key or value token: mostly plain text and well-formed escapes,
    // with broken escapes, plus signs, spaces and arbitrary bytes mixed in.
    task automatic add_token(input bit cookie);
        int len;
        int r;
        if (cookie && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
        end
        len = $urandom_range(0, 5);
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                case ($urandom_range(0, 2))
                    0:       line_q.push_back(8'("a" + $urandom_range(0, 25)));
                    1:       line_q.push_back(8'("A" + $urandom_range(0, 25)));
                    default: line_q.push_back(8'("0" + $urandom_range(0, 9)));
                endcase
            end else if (r < 65) begin
                line_q.push_back(CH_PERCENT);
                line_q.push_back(hex_char($urandom_range(0, 15), 1'($urandom)));
                if ($urandom_range(0, 5) != 0) begin
                    line_q.push_back(hex_char($urandom_range(0, 15), 1'($urandom)));
                end
            end else if (r < 72) begin
                // Escape with arbitrary digit bytes.
                line_q.push_back(CH_PERCENT);
                line_q.push_back(8'($urandom_range(1, 255)));
            end else if (r < 80) begin
                line_q.push_back(CH_PLUS);
            end else if (r < 88) begin
                line_q.push_back(CH_SPACE);
            end else begin
                line_q.push_back(8'($urandom_range(1, 255)));
            end
        end
    endtask

    // Builds one random string into line_q: usually key=value pairs joined by
    // the separator of the mode, sometimes pure noise.
    task automatic build_string(input bit cookie);
        int n_pairs;
        line_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            n_pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9)
                                                  : $urandom_range(1, 4);
            for (int i = 0; i < n_pairs; i++) begin
                add_token(cookie);
                if ($urandom_range(0, 9) != 0) begin
                    line_q.push_back(CH_EQUALS);
                    add_token(cookie);
                end
                if (i < n_pairs - 1 || $urandom_range(0, 3) == 0) begin
                    line_q.push_back(cookie ? CH_SEMI : CH_AMP);
                end
            end
        end
        if (line_q.size() == 0) begin
            line_q.push_back("x");
        end
    endtask

    // Sends one word and returns on the falling edge after it was taken.
    // Valid stays high so that the next word can follow without a gap.
    task automatic send_word(input logic [7:0] val, input logic at_end);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tlast  <= at_end;
        do begin
            @(posedge clk);
        end while (!s_tready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++) begin
            send_word(line_q[i], i == line_q.size() - 1);
        end
        strings_sent++;
    endtask

    // Stops the input stream and waits for every predicted word to come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_words != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Writes both registers on back-to-back cycles; the write enable stays
    // high across them and drops after the second.
    task automatic configure(input bit cookie, input logic [7:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COOKIE_MODE;
        cfg_wdata <= 8'(cookie);
        @(negedge clk);
        cfg_index <= CFG_MAX_TOKENS;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    initial begin
        bit         mode;
        logic [7:0] limit;
        int         phase_start;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed query string: key with an empty name, lowercase escape,
        // plus as space, non-hex first digit, hex then non-hex second digit,
        // a zero byte and an all-ones byte, and a final value whose escape
        // is cut off by the end of the string.
        configure(1'b0, 8'd255);
        line_q.delete();
        add_text("=%4a+%zz%4g&");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        add_text("=%4");
        send_line();
        drain();

        // Directed cookie string: leading space skipped, an escape cut by a
        // space, percent and plus used as escape digits, and a separator on
        // the last byte, which yields two result words.
        configure(1'b1, 8'd255);
        line_q.delete();
        add_text(" a%4 b=%%+;");
        send_line();
        drain();

        // Directed overflow: with a limit of one, the second token overflows
        // and the rest of the string is ignored until its last byte.
        configure(1'b0, 8'd1);
        line_q.delete();
        add_text("=&q");
        send_line();
        drain();

        // Random phases over both modes and a spread of token limits,
        // including the extremes.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            mode = p[0];
            case (p)
                0, 1:    limit = 8'd255;
                2:       limit = 8'd0;
                3:       limit = 8'd1;
                4:       limit = 8'd3;
                5:       limit = 8'd2;
                default: limit = 8'($urandom_range(4, 12));
            endcase
            configure(mode, limit);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 6) == 0) begin
                    src_calm = ~src_calm;
                end
                build_string(mode);
                send_line();
            end
            drain();
        end

        repeat (8) @(negedge clk);
        $display("Sent %0d bytes in %0d strings under %0d register settings",
                 bytes_sent, strings_sent, settings_used);
        $display("(query and cookie modes, token limits 0 to 255); %0d result words compared.",
                 checked_words);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
